/* hw/rtl/atcp_pkg.sv */
// ----------------------------------------------------------------------------
// atcp_pkg
// Types, character codes and the shared d:hh:mm:ss: field parser used by the
// time and pill command paths of the command parser.
// ----------------------------------------------------------------------------
package atcp_pkg;

  localparam int TIME_PFX_LEN = 15;
  localparam int PILL_PFX_LEN = 8;

  localparam int SLOT_W  = 4;
  localparam int TOTAL_W = 5;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // field positions of d:hh:mm:ss:
  localparam logic [3:0] FP_DAY    = 4'd0;
  localparam logic [3:0] FP_SEP_D  = 4'd1;
  localparam logic [3:0] FP_HOUR_T = 4'd2;
  localparam logic [3:0] FP_HOUR_U = 4'd3;
  localparam logic [3:0] FP_SEP_H  = 4'd4;
  localparam logic [3:0] FP_MIN_T  = 4'd5;
  localparam logic [3:0] FP_MIN_U  = 4'd6;
  localparam logic [3:0] FP_SEP_M  = 4'd7;
  localparam logic [3:0] FP_SEC_T  = 4'd8;
  localparam logic [3:0] FP_SEC_U  = 4'd9;
  localparam logic [3:0] FP_END    = 4'd10;

  localparam logic [3:0] DAY_MAX    = 4'd7;
  localparam logic [3:0] HOUR_T_MAX = 4'd2;
  localparam logic [3:0] MIN_T_MAX  = 4'd5;
  localparam logic [3:0] SEC_T_MAX  = 4'd6;
  localparam logic [3:0] UNIT_MAX   = 4'd9;

  typedef enum logic [1:0] {
    EV_NONE         = 2'd0,
    EV_TIME_SET     = 2'd1,
    EV_LIST_END     = 2'd2,
    EV_ENTRY_STORED = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    PS_REJECT   = 2'd0,
    PS_CONSUMED = 2'd1,
    PS_COMPLETE = 2'd2
  } pstat_t;

  typedef struct packed {
    logic [2:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] second;
  } clock_t;

  typedef struct packed {
    pstat_t     stat;
    logic [3:0] fpos;
    clock_t     entry;
  } pstep_t;

  typedef struct packed {
    event_t               ev;
    clock_t               shown;
    logic [SLOT_W-1:0]    slot;
    logic [TOTAL_W-1:0]   total;
    logic                 full;
  } result_t;

  function automatic logic [7:0] time_prefix_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h41; // A
      4'd1:    ch = 8'h54; // T
      4'd2:    ch = 8'h2B; // +
      4'd3:    ch = 8'h43; // C
      4'd4:    ch = 8'h55; // U
      4'd5:    ch = 8'h52; // R
      4'd6:    ch = 8'h52; // R
      4'd7:    ch = 8'h45; // E
      4'd8:    ch = 8'h4E; // N
      4'd9:    ch = 8'h54; // T
      4'd10:   ch = 8'h54; // T
      4'd11:   ch = 8'h49; // I
      4'd12:   ch = 8'h4D; // M
      4'd13:   ch = 8'h45; // E
      4'd14:   ch = 8'h3A; // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] pill_prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h41; // A
      3'd1:    ch = 8'h54; // T
      3'd2:    ch = 8'h2B; // +
      3'd3:    ch = 8'h50; // P
      3'd4:    ch = 8'h49; // I
      3'd5:    ch = 8'h4C; // L
      3'd6:    ch = 8'h4C; // L
      default: ch = 8'h3A; // :
    endcase
    return ch;
  endfunction

  // one parse step at field position fpos on character c
  function automatic pstep_t parse_step(input logic [3:0] fpos, input logic [7:0] c,
                                        input clock_t cur);
    logic       is_dig;
    logic [3:0] d;
    pstep_t     r;
    is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
    d       = c[3:0];
    r.stat  = PS_CONSUMED;
    r.fpos  = fpos + 4'd1;
    r.entry = cur;
    unique case (fpos)
      FP_DAY: begin
        if (is_dig && d <= DAY_MAX) r.entry.day = d[2:0];
        else r.stat = PS_REJECT;
      end
      FP_HOUR_T: begin
        if (is_dig && d <= HOUR_T_MAX) r.entry.hour = 5'(d) * 5'd10;
        else r.stat = PS_REJECT;
      end
      FP_HOUR_U: begin
        if (is_dig && d <= UNIT_MAX) r.entry.hour = cur.hour + 5'(d);
        else r.stat = PS_REJECT;
      end
      FP_MIN_T: begin
        if (is_dig && d <= MIN_T_MAX) r.entry.minute = 6'(d) * 6'd10;
        else r.stat = PS_REJECT;
      end
      FP_MIN_U: begin
        if (is_dig && d <= UNIT_MAX) r.entry.minute = cur.minute + 6'(d);
        else r.stat = PS_REJECT;
      end
      FP_SEC_T: begin
        if (is_dig && d <= SEC_T_MAX) r.entry.second = 7'(d) * 7'd10;
        else r.stat = PS_REJECT;
      end
      FP_SEC_U: begin
        if (is_dig && d <= UNIT_MAX) r.entry.second = cur.second + 7'(d);
        else r.stat = PS_REJECT;
      end
      FP_SEP_D, FP_SEP_H, FP_SEP_M: begin
        if (c != CH_COLON) r.stat = PS_REJECT;
      end
      FP_END: begin
        r.stat = (c == CH_COLON) ? PS_COMPLETE : PS_REJECT;
        r.fpos = FP_DAY;
      end
      default: begin
        r.stat = PS_REJECT;
      end
    endcase
    if (r.stat == PS_REJECT) r.fpos = FP_DAY;
    return r;
  endfunction

endpackage

/* hw/rtl/atcp_pill_mem.sv */
// ----------------------------------------------------------------------------
// atcp_pill_mem
// Pill table storage: one write port, one registered read port, with the
// write of the same cycle forwarded to the read data.
// ----------------------------------------------------------------------------
module atcp_pill_mem #(
  parameter int DEPTH = 16,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [IDX_W-1:0]       wr_addr,
  input  atcp_pkg::clock_t       wr_data,
  input  logic [IDX_W-1:0]       rd_addr,
  output atcp_pkg::clock_t       rd_data
);

  atcp_pkg::clock_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (wr_en && wr_addr == rd_addr) rd_data <= wr_data;
    else rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/atcp_ctrl.sv */
// ----------------------------------------------------------------------------
// atcp_ctrl
// Prefix matchers, shared field counter, current time and pill counters.
// Reads the pill entry being built; writes it back on consumed bytes with room.
// ----------------------------------------------------------------------------
module atcp_ctrl #(
  parameter int TABLE_DEPTH = 16,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  input  atcp_pkg::clock_t     rd_entry,
  output logic                 wr_en,
  output logic [IDX_W-1:0]     wr_addr,
  output atcp_pkg::clock_t     wr_data,
  output logic [IDX_W-1:0]     rd_addr,
  output atcp_pkg::result_t    res
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SW    = (CNT_W > atcp_pkg::SLOT_W) ? CNT_W : atcp_pkg::SLOT_W;
  localparam int TW    = atcp_pkg::TOTAL_W;

  logic [3:0]        tpos, tpos_next;
  logic              t_act, t_act_next;
  logic [2:0]        ppos, ppos_next;
  logic              p_act, p_act_next;
  logic [CNT_W-1:0]  parsed, parsed_next;
  logic [CNT_W-1:0]  total, total_next;
  logic [3:0]        fpos, fpos_next;
  atcp_pkg::clock_t  now_t, now_next;
  atcp_pkg::clock_t  drop, drop_next;

  atcp_pkg::pstep_t  t_step, p_step;
  atcp_pkg::clock_t  tgt;
  logic [3:0]        fp1;
  logic              room;
  logic [SW-1:0]     slot_w;

  assign room    = parsed < CNT_W'(TABLE_DEPTH);
  assign tgt     = room ? rd_entry : drop;
  assign t_step  = atcp_pkg::parse_step(fpos, rx_byte, now_t);
  assign fp1     = t_act ? t_step.fpos : fpos;
  assign p_step  = atcp_pkg::parse_step(fp1, rx_byte, tgt);
  assign wr_addr = parsed[IDX_W-1:0];
  assign wr_data = p_step.entry;
  assign slot_w  = SW'(parsed);

  // next item reads the entry it will modify
  assign rd_addr = rst ? '0 : parsed_next[IDX_W-1:0];

  always_comb begin
    tpos_next   = tpos;
    t_act_next  = t_act;
    ppos_next   = ppos;
    p_act_next  = p_act;
    parsed_next = parsed;
    total_next  = total;
    fpos_next   = fpos;
    now_next    = now_t;
    drop_next   = drop;
    wr_en       = 1'b0;
    res.ev      = atcp_pkg::EV_NONE;
    res.shown   = '0;
    res.slot    = '0;
    res.full    = 1'b0;
    if (accept) begin
      fpos_next = fp1;
      if (t_act) begin
        now_next = t_step.entry;
        if (t_step.stat != atcp_pkg::PS_CONSUMED) t_act_next = 1'b0;
      end else if (rx_byte == atcp_pkg::time_prefix_char(tpos)) begin
        if (tpos == 4'(atcp_pkg::TIME_PFX_LEN - 1)) begin
          tpos_next  = '0;
          t_act_next = 1'b1;
        end else begin
          tpos_next = tpos + 4'd1;
        end
      end else begin
        tpos_next = '0;
      end

      if (t_act && t_step.stat == atcp_pkg::PS_COMPLETE) begin
        // completed time command keeps the byte from the pill side
        res.ev    = atcp_pkg::EV_TIME_SET;
        res.shown = t_step.entry;
      end else if (p_act) begin
        if (rx_byte == atcp_pkg::CH_E) begin
          p_act_next  = 1'b0;
          parsed_next = '0;
          res.ev      = atcp_pkg::EV_LIST_END;
        end else begin
          fpos_next = p_step.fpos;
          unique case (p_step.stat)
            atcp_pkg::PS_REJECT: begin
              p_act_next  = 1'b0;
              parsed_next = '0;
            end
            atcp_pkg::PS_CONSUMED: begin
              if (room) wr_en = 1'b1;
              else drop_next = p_step.entry;
            end
            atcp_pkg::PS_COMPLETE: begin
              res.shown = tgt;
              if (room) begin
                res.slot    = slot_w[atcp_pkg::SLOT_W-1:0];
                parsed_next = parsed + CNT_W'(1);
                total_next  = parsed + CNT_W'(1);
                res.ev      = atcp_pkg::EV_ENTRY_STORED;
              end else begin
                res.full = 1'b1;
              end
            end
            default: begin
              p_act_next = p_act;
            end
          endcase
        end
      end else if (rx_byte == atcp_pkg::pill_prefix_char(ppos)) begin
        if (ppos == 3'(atcp_pkg::PILL_PFX_LEN - 1)) begin
          ppos_next  = '0;
          p_act_next = 1'b1;
        end else begin
          ppos_next = ppos + 3'd1;
        end
      end else begin
        ppos_next = '0;
      end
    end
    res.total = TW'(total_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tpos   <= '0;
      t_act  <= 1'b0;
      ppos   <= '0;
      p_act  <= 1'b0;
      parsed <= '0;
      total  <= '0;
      fpos   <= '0;
      now_t  <= '0;
      drop   <= '0;
    end else begin
      tpos   <= tpos_next;
      t_act  <= t_act_next;
      ppos   <= ppos_next;
      p_act  <= p_act_next;
      parsed <= parsed_next;
      total  <= total_next;
      fpos   <= fpos_next;
      now_t  <= now_next;
      drop   <= drop_next;
    end
  end

endmodule

/* hw/rtl/atcp_out_skid.sv */
// ----------------------------------------------------------------------------
// atcp_out_skid
// Two-deep result buffer: output register plus skid register, so a new
// transaction can be taken while the current result waits.
// ----------------------------------------------------------------------------
module atcp_out_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  atcp_pkg::result_t   push_res,
  input  logic                stall,
  output logic                valid,
  output atcp_pkg::result_t   res,
  output logic                full
);

  logic              skid_valid;
  atcp_pkg::result_t skid_res;
  logic              out_free;

  assign out_free = !valid || !stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        valid      <= 1'b1;
        res        <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        valid <= push;
        if (push) res <= push_res;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_res   <= push_res;
    end
  end

endmodule

/* hw/rtl/at_time_command_parser.sv */
// ----------------------------------------------------------------------------
// at_time_command_parser
// Serial command parser for current-time and pill-list commands.
// ----------------------------------------------------------------------------
// Bytes enter on rx_valid / rx_stall / rx_byte; a transaction completes when
// rx_valid is high and rx_stall is low. Every accepted byte yields exactly
// one result on res_valid / res_stall with event_res, the time fields,
// entry_slot, entry_total and table_full.
// Results are registered in the output or, on a stall, the skid register.
// Throughput: one byte per cycle while rx_stall is low. The pill entry under
// construction lives in the pill table memory; its read for the next byte is
// issued in the same cycle as the write-back, with written data forwarded.
// Reset clears both prefix matchers, the field counter, the current time,
// the pill counters and the drop entry; pill table contents stay undefined
// until written. No clearing pass is needed, the block accepts at once.
// When the receiver holds res_stall, one more result is kept in a skid
// register; rx_stall then rises until the skid register empties.
// ----------------------------------------------------------------------------
module at_time_command_parser #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] event_res,
  output logic [2:0] time_day,
  output logic [4:0] time_hour,
  output logic [5:0] time_minute,
  output logic [6:0] time_second,
  output logic [3:0] entry_slot,
  output logic [4:0] entry_total,
  output logic       table_full
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic              accept;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;
  atcp_pkg::clock_t  wr_data;
  atcp_pkg::clock_t  rd_entry;
  atcp_pkg::result_t step_res;
  atcp_pkg::result_t out_res;
  logic              skid_full;

  assign rx_stall = skid_full;
  assign accept   = rx_valid && !skid_full;

  atcp_pill_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  atcp_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .res      (step_res)
  );

  atcp_out_skid u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_res (step_res),
    .stall    (res_stall),
    .valid    (res_valid),
    .res      (out_res),
    .full     (skid_full)
  );

  assign event_res   = out_res.ev;
  assign time_day    = out_res.shown.day;
  assign time_hour   = out_res.shown.hour;
  assign time_minute = out_res.shown.minute;
  assign time_second = out_res.shown.second;
  assign entry_slot  = out_res.slot;
  assign entry_total = out_res.total;
  assign table_full  = out_res.full;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the serial command parser with current-time commands, pill lists,
// malformed commands and line noise, one character per transaction, and
// checks every result against a cycle-free model of the parser state.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [1:0] event_res;
  logic [2:0] time_day;
  logic [4:0] time_hour;
  logic [5:0] time_minute;
  logic [6:0] time_second;
  logic [3:0] entry_slot;
  logic [4:0] entry_total;
  logic       table_full;

  at_time_command_parser #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .rx_byte(rx_byte),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .event_res(event_res),
    .time_day(time_day),
    .time_hour(time_hour),
    .time_minute(time_minute),
    .time_second(time_second),
    .entry_slot(entry_slot),
    .entry_total(entry_total),
    .table_full(table_full)
  );

  always #1 clk = ~clk;

  string time_cmd    = "AT+CURRENTTIME:";
  string pill_cmd    = "AT+PILL:";
  string noise_chars = ":0123456789AETP+";

  // parser model state
  logic               time_on = 1'b0;
  logic               pill_on = 1'b0;
  int                 time_idx = 0;
  int                 pill_idx = 0;
  int                 pill_cnt = 0;
  logic [3:0]         fld_pos = atcp_pkg::FP_DAY;
  logic [4:0]         pill_total = '0;
  atcp_pkg::clock_t   now_clk = '0;
  atcp_pkg::clock_t   drop_clk = '0;
  atcp_pkg::clock_t   pill_mem [TABLE_DEPTH];

  atcp_pkg::result_t  decoded_q [$];
  logic [7:0]         line_q [$];

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int sent_cnt = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int n_time = 0;
  int n_entry = 0;
  int n_end = 0;
  int n_drop = 0;

  // one step of the shared d:hh:mm:ss: field counter
  task automatic field_step(input logic [7:0] c, inout atcp_pkg::clock_t t,
                            output atcp_pkg::pstat_t st);
    logic       dig;
    logic [3:0] d;
    dig = (c >= atcp_pkg::CH_ZERO) && (c <= atcp_pkg::CH_NINE);
    d   = 4'(c - atcp_pkg::CH_ZERO);
    st  = atcp_pkg::PS_CONSUMED;
    case (fld_pos)
      atcp_pkg::FP_DAY: begin
        if (dig && d <= atcp_pkg::DAY_MAX) t.day = d[2:0];
        else st = atcp_pkg::PS_REJECT;
      end
      atcp_pkg::FP_HOUR_T: begin
        if (dig && d <= atcp_pkg::HOUR_T_MAX) t.hour = 5'(d * 10);
        else st = atcp_pkg::PS_REJECT;
      end
      atcp_pkg::FP_HOUR_U: begin
        if (dig) t.hour = 5'(t.hour + d);
        else st = atcp_pkg::PS_REJECT;
      end
      atcp_pkg::FP_MIN_T: begin
        if (dig && d <= atcp_pkg::MIN_T_MAX) t.minute = 6'(d * 10);
        else st = atcp_pkg::PS_REJECT;
      end
      atcp_pkg::FP_MIN_U: begin
        if (dig) t.minute = 6'(t.minute + d);
        else st = atcp_pkg::PS_REJECT;
      end
      atcp_pkg::FP_SEC_T: begin
        if (dig && d <= atcp_pkg::SEC_T_MAX) t.second = 7'(d * 10);
        else st = atcp_pkg::PS_REJECT;
      end
      atcp_pkg::FP_SEC_U: begin
        if (dig) t.second = 7'(t.second + d);
        else st = atcp_pkg::PS_REJECT;
      end
      atcp_pkg::FP_SEP_D, atcp_pkg::FP_SEP_H, atcp_pkg::FP_SEP_M: begin
        if (c != atcp_pkg::CH_COLON) st = atcp_pkg::PS_REJECT;
      end
      atcp_pkg::FP_END: begin
        st = (c == atcp_pkg::CH_COLON) ? atcp_pkg::PS_COMPLETE : atcp_pkg::PS_REJECT;
      end
      default: st = atcp_pkg::PS_REJECT;
    endcase
    fld_pos = (st == atcp_pkg::PS_CONSUMED) ? fld_pos + 4'd1 : atcp_pkg::FP_DAY;
  endtask

  task automatic decode_char(input logic [7:0] c, output atcp_pkg::result_t r);
    atcp_pkg::pstat_t st;
    atcp_pkg::clock_t ent;
    logic             room;
    logic             stopped;
    r       = '0;
    stopped = 1'b0;
    if (time_on) begin
      field_step(c, now_clk, st);
      if (st != atcp_pkg::PS_CONSUMED) time_on = 1'b0;
      // a finished time command keeps the character from the pill side
      if (st == atcp_pkg::PS_COMPLETE) begin
        r.ev    = atcp_pkg::EV_TIME_SET;
        r.shown = now_clk;
        stopped = 1'b1;
      end
    end else if (c == time_cmd[time_idx]) begin
      time_idx++;
      if (time_idx == atcp_pkg::TIME_PFX_LEN) begin
        time_idx = 0;
        time_on  = 1'b1;
      end
    end else begin
      time_idx = 0;
    end
    if (!stopped) begin
      if (pill_on) begin
        if (c == atcp_pkg::CH_E) begin
          pill_on  = 1'b0;
          pill_cnt = 0;
          r.ev     = atcp_pkg::EV_LIST_END;
        end else begin
          room = (pill_cnt < TABLE_DEPTH);
          if (room) ent = pill_mem[pill_cnt];
          else ent = drop_clk;
          field_step(c, ent, st);
          if (room) pill_mem[pill_cnt] = ent;
          else drop_clk = ent;
          if (st == atcp_pkg::PS_REJECT) begin
            pill_on  = 1'b0;
            pill_cnt = 0;
          end else if (st == atcp_pkg::PS_COMPLETE) begin
            if (room) begin
              r.ev       = atcp_pkg::EV_ENTRY_STORED;
              r.slot     = 4'(pill_cnt);
              pill_cnt++;
              pill_total = 5'(pill_cnt);
            end else begin
              r.full = 1'b1;
            end
            r.shown = ent;
          end
        end
      end else if (c == pill_cmd[pill_idx]) begin
        pill_idx++;
        if (pill_idx == atcp_pkg::PILL_PFX_LEN) begin
          pill_idx = 0;
          pill_on  = 1'b1;
        end
      end else begin
        pill_idx = 0;
      end
    end
    r.total = pill_total;
  endtask

  task automatic send_byte(input logic [7:0] c);
    atcp_pkg::result_t r;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    decode_char(c, r);
    decoded_q.push_back(r);
    rx_valid <= 1'b1;
    rx_byte  <= c;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic send_line();
    while (line_q.size() != 0) send_byte(line_q.pop_front());
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic add_clock(input int d, input int ht, input int hu, input int mt,
                           input int mu, input int st, input int su);
    line_q.push_back(8'(atcp_pkg::CH_ZERO + d));
    line_q.push_back(atcp_pkg::CH_COLON);
    line_q.push_back(8'(atcp_pkg::CH_ZERO + ht));
    line_q.push_back(8'(atcp_pkg::CH_ZERO + hu));
    line_q.push_back(atcp_pkg::CH_COLON);
    line_q.push_back(8'(atcp_pkg::CH_ZERO + mt));
    line_q.push_back(8'(atcp_pkg::CH_ZERO + mu));
    line_q.push_back(atcp_pkg::CH_COLON);
    line_q.push_back(8'(atcp_pkg::CH_ZERO + st));
    line_q.push_back(8'(atcp_pkg::CH_ZERO + su));
    line_q.push_back(atcp_pkg::CH_COLON);
  endtask

  task automatic add_rand_clock();
    add_clock($urandom_range(0, 7), $urandom_range(0, 2), $urandom_range(0, 9),
              $urandom_range(0, 5), $urandom_range(0, 9), $urandom_range(0, 6),
              $urandom_range(0, 9));
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic check_result();
    atcp_pkg::result_t want;
    if (decoded_q.size() == 0) begin
      $error("result with no pending transaction: event_res %0d", event_res);
      fail_cnt++;
    end else begin
      want = decoded_q.pop_front();
      check_field("event_res", 8'(want.ev), 8'(event_res));
      check_field("time_day", 8'(want.shown.day), 8'(time_day));
      check_field("time_hour", 8'(want.shown.hour), 8'(time_hour));
      check_field("time_minute", 8'(want.shown.minute), 8'(time_minute));
      check_field("time_second", 8'(want.shown.second), 8'(time_second));
      check_field("entry_slot", 8'(want.slot), 8'(entry_slot));
      check_field("entry_total", 8'(want.total), 8'(entry_total));
      check_field("table_full", 8'(want.full), 8'(table_full));
      case (want.ev)
        atcp_pkg::EV_TIME_SET:     n_time++;
        atcp_pkg::EV_ENTRY_STORED: n_entry++;
        atcp_pkg::EV_LIST_END:     n_end++;
        default:                   if (want.full) n_drop++;
      endcase
    end
  endtask

  // result side: checking plus bursts of back-pressure
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (res_valid && !res_stall) check_result();
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        hold_left = $urandom_range(0, 7);
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic test_time_command();
    add_text(time_cmd);
    add_clock(7, 2, 9, 5, 9, 6, 9);
    add_text(time_cmd);
    add_clock(0, 0, 0, 0, 0, 0, 0);
    send_line();
  endtask

  task automatic test_pill_list();
    add_text(pill_cmd);
    add_clock(7, 2, 9, 5, 9, 6, 9);
    add_clock(0, 0, 0, 0, 0, 0, 0);
    add_text("E");
    // empty list
    add_text(pill_cmd);
    add_text("E");
    // end mark inside an entry leaves the field counter where it was
    add_text(pill_cmd);
    add_text("1:2E");
    add_text(pill_cmd);
    add_text("3:00:00:");
    add_clock(1, 1, 1, 2, 2, 3, 3);
    add_text("E");
    send_line();
  endtask

  task automatic test_rejects();
    add_text(time_cmd);
    add_text("8");
    add_text(time_cmd);
    add_text("/");
    add_text(pill_cmd);
    add_text("1:3");
    add_text(pill_cmd);
    add_text("2:2A");
    add_text(pill_cmd);
    add_text("3:19:6");
    add_text(time_cmd);
    add_text("4:12:30:7");
    add_text(time_cmd);
    add_text("5:12;");
    add_text(time_cmd);
    add_text("6:12:30:45x");
    // broken prefixes, stray end mark and digits
    add_text("AT+CUX");
    add_text("AAT+PILL:");
    add_text("E1");
    send_line();
  endtask

  task automatic test_table_full();
    add_text(pill_cmd);
    repeat (TABLE_DEPTH + 2) add_rand_clock();
    add_text("E");
    send_line();
  endtask

  task automatic test_random_traffic(input int n_items, input bit vary_idle);
    int    stop_at;
    int    pick;
    int    k;
    int    i;
    string cmd;
    stop_at = sent_cnt + n_items;
    while (sent_cnt < stop_at) begin
      if (vary_idle && $urandom_range(0, 9) == 0) begin
        gap_pct   = 15 * $urandom_range(0, 2);
        stall_pct = 15 * $urandom_range(0, 2);
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        add_text(time_cmd);
        add_rand_clock();
      end else if (pick < 75) begin
        add_text(pill_cmd);
        if ($urandom_range(0, 7) == 0) k = $urandom_range(TABLE_DEPTH - 1, TABLE_DEPTH + 3);
        else k = $urandom_range(0, 3);
        repeat (k) add_rand_clock();
        if ($urandom_range(0, 9) != 0) add_text("E");
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(0, 1) == 0) line_q.push_back(8'($urandom_range(0, 255)));
          else line_q.push_back(noise_chars[$urandom_range(0, noise_chars.len() - 1)]);
        end
      end else begin
        cmd = ($urandom_range(0, 1) == 0) ? time_cmd : pill_cmd;
        k   = $urandom_range(1, cmd.len() - 1);
        for (i = 0; i < k; i++) line_q.push_back(cmd[i]);
        line_q.push_back(8'($urandom_range(0, 255)));
      end
      // occasional corrupted character anywhere in the line
      if (line_q.size() != 0 && $urandom_range(0, 4) == 0)
        line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
      send_line();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    gap_pct   = 25;
    stall_pct = 25;
    test_time_command();
    test_pill_list();
    test_rejects();
    test_table_full();
    test_random_traffic(550, 1'b1);
    gap_pct   = 0;
    stall_pct = 0;
    test_random_traffic(150, 1'b0);
    rx_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("sent %0d characters: %0d time commands, %0d pill entries stored,",
             sent_cnt, n_time, n_entry);
    $display("%0d pill lists closed, %0d entries dropped on a full table", n_end, n_drop);
    if (fail_cnt == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
